/* rtl/core/gmds_pkg.sv */
// ----------------------------------------------------------------------------
// gmds_pkg
// Shared constants, codes and types of the grid maze DFS solver.
// ----------------------------------------------------------------------------
package gmds_pkg;

    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    localparam int POS_W  = 5;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 3;
    localparam int CFG_W  = 6;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [CFG_W-1:0] CFG_RST = 6'd32;

    // register select bit of paddr
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

    localparam logic [1:0] CELL_OPEN = 2'd0;
    localparam logic [1:0] CELL_PATH = 2'd2;
    localparam logic [1:0] CELL_DEAD = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_FWD    = 3'd0,
        ST_BACK   = 3'd1,
        ST_GOAL   = 3'd2,
        ST_NOPATH = 3'd3,
        ST_ACK    = 3'd4
    } status_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stack_ctl_t;

endpackage

/* rtl/core/gmds_req_if.sv */
// ----------------------------------------------------------------------------
// gmds_req_if
// Request channel: load, start or step beats with valid/ready.
// ----------------------------------------------------------------------------
interface gmds_req_if;
    logic                         valid;
    logic                         ready;
    logic [gmds_pkg::REQ_W-1:0]   req_type;
    logic [gmds_pkg::POS_W-1:0]   cell_row;
    logic [gmds_pkg::POS_W-1:0]   cell_col;
    logic                         is_wall;

    modport source (output valid, req_type, cell_row, cell_col, is_wall, input ready);
    modport sink   (input valid, req_type, cell_row, cell_col, is_wall, output ready);
endinterface

/* rtl/core/gmds_rsp_if.sv */
// ----------------------------------------------------------------------------
// gmds_rsp_if
// Response channel: walker position and status beats with valid/ready.
// ----------------------------------------------------------------------------
interface gmds_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [gmds_pkg::POS_W-1:0]   pos_row;
    logic [gmds_pkg::POS_W-1:0]   pos_col;
    logic [gmds_pkg::STAT_W-1:0]  status;

    modport source (output valid, pos_row, pos_col, status, input ready);
    modport sink   (input valid, pos_row, pos_col, status, output ready);
endinterface

/* rtl/core/gmds_apb_regs.sv */
// ----------------------------------------------------------------------------
// gmds_apb_regs
// APB register file for rows/cols in use; derives the clamped goal cell.
// ----------------------------------------------------------------------------
module gmds_apb_regs #(
    parameter int MAX_ROWS = gmds_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gmds_pkg::MAX_COLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmds_pkg::APB_AW-1:0]   paddr,
    input  logic [gmds_pkg::APB_DW-1:0]   pwdata,
    output logic [gmds_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [$clog2(MAX_ROWS)-1:0]   goal_row,
    output logic [$clog2(MAX_COLS)-1:0]   goal_col
);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    logic [gmds_pkg::CFG_W-1:0] rows_reg;
    logic [gmds_pkg::CFG_W-1:0] cols_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= gmds_pkg::CFG_RST;
            cols_reg <= gmds_pkg::CFG_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == gmds_pkg::REG_ROWS)
                rows_reg <= pwdata[gmds_pkg::CFG_W-1:0];
            else
                cols_reg <= pwdata[gmds_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == gmds_pkg::REG_ROWS)
            prdata = gmds_pkg::APB_DW'(rows_reg);
        else
            prdata = gmds_pkg::APB_DW'(cols_reg);
    end

    // zero counts as one, anything above the maximum counts as the maximum
    always_comb
    begin
        if (rows_reg == '0)
            goal_row = '0;
        else if (32'(rows_reg) > MAX_ROWS)
            goal_row = RW'(MAX_ROWS - 1);
        else
            goal_row = RW'(rows_reg - 6'd1);

        if (cols_reg == '0)
            goal_col = '0;
        else if (32'(cols_reg) > MAX_COLS)
            goal_col = CW'(MAX_COLS - 1);
        else
            goal_col = CW'(cols_reg - 6'd1);
    end
endmodule

/* rtl/core/gmds_stack.sv */
// ----------------------------------------------------------------------------
// gmds_stack
// Path stack in a synchronous RAM; top entry kept in a registered read.
// ----------------------------------------------------------------------------
module gmds_stack #(
    parameter int DEPTH = gmds_pkg::MAX_ROWS_DEF * gmds_pkg::MAX_COLS_DEF,
    parameter int DW    = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gmds_pkg::stack_ctl_t  ctl,
    input  logic [DW-1:0]         push_data,
    output logic                  empty,
    output logic [DW-1:0]         top
);
    localparam int IW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DW-1:0]   stk_mem [DEPTH];
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic [CNTW-1:0] cnt_dec;
    logic [DW-1:0]   top_reg;
    logic            not_full;

    assign not_full = cnt_reg < CNTW'(DEPTH);
    assign cnt_dec  = cnt_reg - 1'b1;
    assign empty    = (cnt_reg == '0);
    assign top      = top_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.clear)
            cnt_next = '0;
        else if (ctl.push && not_full)
            cnt_next = cnt_reg + 1'b1;
        else if (ctl.pop && !empty)
            cnt_next = cnt_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // a full stack drops the push
    always_ff @(posedge clk)
    begin
        if (ctl.push && not_full && !ctl.clear)
            stk_mem[cnt_reg[IW-1:0]] <= push_data;
        top_reg <= stk_mem[cnt_dec[IW-1:0]];
    end
endmodule

/* rtl/core/gmds_walker.sv */
// ----------------------------------------------------------------------------
// gmds_walker
// Cell RAM and walker sequencer: reads the four neighbors one per cycle,
// then marks, pushes or pops and moves.
// ----------------------------------------------------------------------------
module gmds_walker #(
    parameter int MAX_ROWS = gmds_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gmds_pkg::MAX_COLS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [gmds_pkg::REQ_W-1:0]                  req_type,
    input  logic [gmds_pkg::POS_W-1:0]                  cell_row,
    input  logic [gmds_pkg::POS_W-1:0]                  cell_col,
    input  logic                                        is_wall,
    input  logic [$clog2(MAX_ROWS)-1:0]                 goal_row,
    input  logic [$clog2(MAX_COLS)-1:0]                 goal_col,
    output gmds_pkg::stack_ctl_t                        stk_ctl,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] stk_data,
    input  logic                                        stk_empty,
    input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] stk_top,
    output logic                                        res_valid,
    input  logic                                        res_take,
    output logic [gmds_pkg::POS_W-1:0]                  res_row,
    output logic [gmds_pkg::POS_W-1:0]                  res_col,
    output logic [gmds_pkg::STAT_W-1:0]                 res_status
);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int CELLS = 1 << AW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_RESP
    } state_t;

    state_t              state_reg,  state_next;
    logic [RW-1:0]       row_reg,    row_next;
    logic [CW-1:0]       col_reg,    col_next;
    logic                fin_reg,    fin_next;
    logic [1:0]          dir_reg,    dir_next;
    logic [2:0]          open_reg,   open_next;
    gmds_pkg::status_t   status_reg, status_next;

    logic [1:0]          cell_mem [CELLS];
    logic [1:0]          cell_rd_reg;
    logic                cwe;
    logic [AW-1:0]       cwaddr;
    logic [1:0]          cwdata;
    logic [AW-1:0]       craddr;

    logic [RW:0]         nb_row [4];
    logic [CW:0]         nb_col [4];
    logic [3:0]          nb_ok;
    logic [3:0]          open_all;
    logic [1:0]          sel;
    logic                found;
    logic [RW-1:0]       mv_row;
    logic [CW-1:0]       mv_col;
    logic                here_goal;
    logic                mv_goal;

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESP);
    assign res_row    = gmds_pkg::POS_W'(row_reg);
    assign res_col    = gmds_pkg::POS_W'(col_reg);
    assign res_status = status_reg;
    assign here_goal  = (row_reg == goal_row) && (col_reg == goal_col);

    // neighbors in order right, down, up, left; underflow wraps above the goal
    always_comb
    begin
        nb_row[0] = {1'b0, row_reg};
        nb_col[0] = {1'b0, col_reg} + 1'b1;
        nb_row[1] = {1'b0, row_reg} + 1'b1;
        nb_col[1] = {1'b0, col_reg};
        nb_row[2] = {1'b0, row_reg} - 1'b1;
        nb_col[2] = {1'b0, col_reg};
        nb_row[3] = {1'b0, row_reg};
        nb_col[3] = {1'b0, col_reg} - 1'b1;
        for (int d = 0; d < 4; d++)
            nb_ok[d] = (nb_row[d] <= {1'b0, goal_row}) && (nb_col[d] <= {1'b0, goal_col});
    end

    assign craddr   = {nb_row[dir_reg][RW-1:0], nb_col[dir_reg][CW-1:0]};
    assign open_all = {cell_rd_reg == gmds_pkg::CELL_OPEN, open_reg} & nb_ok;

    always_comb
    begin
        sel   = 2'd0;
        found = 1'b0;
        for (int d = 3; d >= 0; d--)
        begin
            if (open_all[d])
            begin
                sel   = 2'(d);
                found = 1'b1;
            end
        end
    end

    assign mv_row  = nb_row[sel][RW-1:0];
    assign mv_col  = nb_col[sel][CW-1:0];
    assign mv_goal = (mv_row == goal_row) && (mv_col == goal_col);

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        fin_next    = fin_reg;
        dir_next    = dir_reg;
        open_next   = open_reg;
        status_next = status_reg;
        cwe         = 1'b0;
        cwaddr      = {row_reg, col_reg};
        cwdata      = gmds_pkg::CELL_PATH;
        stk_ctl     = '0;
        stk_data    = {row_reg, col_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = gmds_pkg::ST_ACK;
                    state_next  = S_RESP;
                    case (req_type)
                        gmds_pkg::REQ_LOAD:
                        begin
                            if ((32'(cell_row) < MAX_ROWS) && (32'(cell_col) < MAX_COLS))
                            begin
                                cwe    = 1'b1;
                                cwaddr = {RW'(cell_row), CW'(cell_col)};
                                cwdata = {1'b0, is_wall};
                            end
                        end
                        gmds_pkg::REQ_START:
                        begin
                            row_next      = '0;
                            col_next      = '0;
                            fin_next      = 1'b0;
                            stk_ctl.clear = 1'b1;
                        end
                        gmds_pkg::REQ_STEP:
                        begin
                            if (fin_reg)
                                status_next = (here_goal && !stk_empty) ?
                                              gmds_pkg::ST_GOAL : gmds_pkg::ST_NOPATH;
                            else
                            begin
                                dir_next   = 2'd0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = gmds_pkg::ST_ACK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (dir_reg != 2'd0)
                    open_next[dir_reg - 2'd1] = (cell_rd_reg == gmds_pkg::CELL_OPEN);
                dir_next = dir_reg + 2'd1;
                if (dir_reg == 2'd3)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_RESP;
                if (found)
                begin
                    cwe          = 1'b1;
                    cwdata       = gmds_pkg::CELL_PATH;
                    stk_ctl.push = 1'b1;
                    row_next     = mv_row;
                    col_next     = mv_col;
                    fin_next     = mv_goal;
                    status_next  = mv_goal ? gmds_pkg::ST_GOAL : gmds_pkg::ST_FWD;
                end
                else if (stk_empty)
                begin
                    fin_next    = 1'b1;
                    status_next = gmds_pkg::ST_NOPATH;
                end
                else
                begin
                    cwe         = 1'b1;
                    cwdata      = gmds_pkg::CELL_DEAD;
                    stk_ctl.pop = 1'b1;
                    row_next    = stk_top[AW-1:CW];
                    col_next    = stk_top[CW-1:0];
                    if ((stk_top[AW-1:CW] == goal_row) && (stk_top[CW-1:0] == goal_col))
                    begin
                        fin_next    = 1'b1;
                        status_next = gmds_pkg::ST_GOAL;
                    end
                    else
                        status_next = gmds_pkg::ST_BACK;
                end
            end
            S_RESP:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            fin_reg    <= 1'b0;
            dir_reg    <= 2'd0;
            open_reg   <= '0;
            status_reg <= gmds_pkg::ST_ACK;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            fin_reg    <= fin_next;
            dir_reg    <= dir_next;
            open_reg   <= open_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cwe)
            cell_mem[cwaddr] <= cwdata;
        cell_rd_reg <= cell_mem[craddr];
    end
endmodule

/* rtl/core/grid_maze_dfs_solver_unit.sv */
// ----------------------------------------------------------------------------
// grid_maze_dfs_solver_unit
// Depth-first maze solver: cell RAM, path stack RAM, APB config, output beat.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type, cell_row, cell_col, is_wall
//   rsp      out  valid/ready    pos_row, pos_col, status
//   apb      in   psel/penable   paddr, pwdata -> prdata, pready
//
// Load, start and finished-step beats go from the idle state straight to the response state.
// Live step beats take four neighbor reads through the single
// cell RAM read port, the decide state and the handoff to the output register.
// The next request is taken while a response beat waits in the output register.
// Reset clears control state only; both RAMs are undefined until written.
// ----------------------------------------------------------------------------
module grid_maze_dfs_solver_unit #(
    parameter int MAX_ROWS = gmds_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gmds_pkg::MAX_COLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    gmds_req_if.sink                      req,
    gmds_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmds_pkg::APB_AW-1:0]   paddr,
    input  logic [gmds_pkg::APB_DW-1:0]   pwdata,
    output logic [gmds_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;

    logic [RW-1:0]                  goal_row;
    logic [CW-1:0]                  goal_col;
    gmds_pkg::stack_ctl_t           stk_ctl;
    logic [AW-1:0]                  stk_data;
    logic                           stk_empty;
    logic [AW-1:0]                  stk_top;
    logic                           res_valid;
    logic                           res_take;
    logic [gmds_pkg::POS_W-1:0]     res_row;
    logic [gmds_pkg::POS_W-1:0]     res_col;
    logic [gmds_pkg::STAT_W-1:0]    res_status;

    logic                           ov_reg;
    logic [gmds_pkg::POS_W-1:0]     orow_reg;
    logic [gmds_pkg::POS_W-1:0]     ocol_reg;
    logic [gmds_pkg::STAT_W-1:0]    ostat_reg;

    gmds_apb_regs #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .goal_row (goal_row),
        .goal_col (goal_col)
    );

    gmds_stack #(
        .DEPTH (MAX_ROWS * MAX_COLS),
        .DW    (AW)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stk_ctl),
        .push_data (stk_data),
        .empty     (stk_empty),
        .top       (stk_top)
    );

    gmds_walker #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .req_type   (req.req_type),
        .cell_row   (req.cell_row),
        .cell_col   (req.cell_col),
        .is_wall    (req.is_wall),
        .goal_row   (goal_row),
        .goal_col   (goal_col),
        .stk_ctl    (stk_ctl),
        .stk_data   (stk_data),
        .stk_empty  (stk_empty),
        .stk_top    (stk_top),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res_row    (res_row),
        .res_col    (res_col),
        .res_status (res_status)
    );

    assign res_take = res_valid && (!ov_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (res_take)
            ov_reg <= 1'b1;
        else if (rsp.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            orow_reg  <= res_row;
            ocol_reg  <= res_col;
            ostat_reg <= res_status;
        end
    end

    assign rsp.valid   = ov_reg;
    assign rsp.pos_row = orow_reg;
    assign rsp.pos_col = ocol_reg;
    assign rsp.status  = ostat_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while previous one in flight");

    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req.ready)
        else $error("request ready while result pending");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> rsp.valid)
        else $error("handed-off result missing from output register");
endmodule
